[design/hnt_pkg.sv]
// Shared types and constants for the hanging note tracker.
// Used by hnt_front, hnt_back and the top level; depends on nothing.
package hnt_pkg;

	localparam int ENTRY_COUNT = 2048;
	localparam int IDX_W       = 11;
	localparam int SCAN_W      = 12;
	localparam int PORT_W      = 3;

	localparam logic [1:0] ACT_TRACK = 2'd0;
	localparam logic [1:0] ACT_FLUSH = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] OP_TRACK = 2'd0;
	localparam logic [1:0] OP_FLUSH = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [31:0] EVENT_MASK  = 32'h8000_00F0;
	localparam logic [31:0] EV_NOTE_ON  = 32'h0000_0090;
	localparam logic [31:0] EV_NOTE_OFF = 32'h0000_0080;
	localparam logic [3:0]  NOTE_ON_HI  = 4'h9;

	typedef struct packed {
		logic [1:0]        op;
		logic [IDX_W-1:0]  idx;
		logic [PORT_W-1:0] port;
		logic              set;
	} cmd_t;

endpackage

[design/hanging_note_tracker.sv]
// Hanging note tracker top: front decoder/queue, back executor over a 2048-entry store.
// Track (back end): a store read, then a write. Flush: decode, a scan up to the next
// sounding entry, then one result per released note, or a done result once the store is
// exhausted. Clear: decode, then a clear of all 2048 entries (one store entry per cycle).
// Two queued words decouple. Reset: control cleared at once, then a store clear with busy
// held high. Results are strobed for one cycle; the receiver cannot stall.
module hanging_note_tracker #(
	parameter int PORT_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] message,
	output logic        result_valid,
	output logic [31:0] out_message,
	output logic        has_note,
	output logic        last_of_run,
	output logic        scan_done
);
	import hnt_pkg::*;

	cmd_t head;
	logic head_valid;
	logic pop;
	logic back_init;

	hnt_front #(
		.PORT_COUNT(PORT_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.message   (message),
		.back_init (back_init),
		.pop       (pop),
		.busy      (busy),
		.head_valid(head_valid),
		.head      (head)
	);

	hnt_back #(
		.PORT_COUNT(PORT_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.back_init   (back_init),
		.result_valid(result_valid),
		.out_message (out_message),
		.has_note    (has_note),
		.last_of_run (last_of_run),
		.scan_done   (scan_done)
	);

endmodule

[design/hnt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/hnt_front.sv]
// Front end: takes command words, decodes them into ops and queues the kept ones (two deep).
// Depends on hnt_pkg.
module hnt_front #(
	parameter int PORT_COUNT = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    action,
	input  logic [31:0]   message,
	input  logic          back_init,
	input  logic          pop,
	output logic          busy,
	output logic          head_valid,
	output hnt_pkg::cmd_t head
);
	import hnt_pkg::*;

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic [31:0] ev;
	logic        is_on;
	logic        is_off;
	logic        port_ok;
	logic        keep;
	logic        push;
	logic        do_pop;
	cmd_t        cmd;

	always_comb begin
		ev      = message & EVENT_MASK;
		is_on   = (ev == EV_NOTE_ON);
		is_off  = (ev == EV_NOTE_OFF);
		port_ok = (message[30:24] < 7'(PORT_COUNT));
		cmd.op   = OP_TRACK;
		cmd.idx  = {message[3:0], message[14:8]};
		cmd.port = message[24 +: PORT_W];
		cmd.set  = is_on && (message[23:16] != 8'd0);
		keep     = 1'b0;
		case (action)
			ACT_TRACK: begin
				cmd.op = OP_TRACK;
				keep   = (is_on || is_off) && port_ok;
			end
			ACT_FLUSH: begin
				cmd.op = OP_FLUSH;
				keep   = 1'b1;
			end
			ACT_CLEAR: begin
				cmd.op = OP_CLEAR;
				keep   = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign busy       = (count_q == 2'd2) || back_init;
	assign push       = start && !busy && keep;
	assign head_valid = (count_q != 2'd0);
	assign do_pop     = pop && head_valid;
	assign head       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push)
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue count out of range");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count did not follow a push");
`endif

endmodule

[design/hnt_back.sv]
// Back end: executes queued ops on the sounding-port store, scans and emits releases.
// Depends on hnt_pkg and hnt_ram.
module hnt_back #(
	parameter int PORT_COUNT = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  hnt_pkg::cmd_t head,
	output logic          pop,
	output logic          back_init,
	output logic          result_valid,
	output logic [31:0]   out_message,
	output logic          has_note,
	output logic          last_of_run,
	output logic          scan_done
);
	import hnt_pkg::*;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_TRK  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]            state_q;
	logic                  init_q;
	logic [IDX_W-1:0]      clr_cnt_q;
	logic [SCAN_W-1:0]     scan_q;
	logic [IDX_W-1:0]      idx_q;
	logic [PORT_COUNT-1:0] mask_q;
	logic                  set_q;
	logic [PORT_COUNT-1:0] bits_q;
	logic [IDX_W-1:0]      ent_q;
	logic                  res_valid_q;
	logic [31:0]           res_msg_q;
	logic                  res_has_q;
	logic                  res_last_q;
	logic                  res_done_q;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [PORT_COUNT-1:0] wdata;
	logic [IDX_W-1:0]      raddr;
	logic [PORT_COUNT-1:0] rdata;
	logic [PORT_COUNT-1:0] head_mask;
	logic [PORT_COUNT-1:0] low_bit;
	logic [PORT_W-1:0]     low_sel;
	logic [PORT_COUNT-1:0] bits_left;
	logic                  scan_end;

	hnt_ram #(
		.WIDTH(PORT_COUNT),
		.DEPTH(ENTRY_COUNT)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		for (int p = 0; p < PORT_COUNT; p++) begin
			head_mask[p] = (head.port == PORT_W'(p));
		end
		// isolate lowest sounding port
		low_bit   = bits_q & (~bits_q + 1'b1);
		bits_left = bits_q & ~low_bit;
		low_sel   = '0;
		for (int p = PORT_COUNT - 1; p >= 0; p--) begin
			if (bits_q[p]) begin
				low_sel = PORT_W'(p);
			end
		end
		scan_end = (scan_q[IDX_W-1:0] == {IDX_W{1'b1}});
	end

	always_comb begin
		pop   = 1'b0;
		we    = 1'b0;
		waddr = idx_q;
		wdata = '0;
		raddr = scan_q[IDX_W-1:0];
		unique case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
			end
			ST_IDLE: begin
				pop = head_valid;
				if (head.op == OP_TRACK) begin
					raddr = head.idx;
				end
			end
			ST_TRK: begin
				we    = 1'b1;
				wdata = set_q ? (rdata | mask_q) : (rdata & ~mask_q);
			end
			ST_SCAN: raddr = scan_q[IDX_W-1:0] + 1'b1;
			ST_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			init_q      <= 1'b1;
			clr_cnt_q   <= '0;
			scan_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == {IDX_W{1'b1}}) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (head_valid) begin
						unique case (head.op)
							OP_TRACK: state_q <= ST_TRK;
							OP_FLUSH: begin
								if (scan_q[SCAN_W-1]) begin
									res_valid_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							OP_CLEAR: begin
								scan_q    <= '0;
								clr_cnt_q <= '0;
								state_q   <= ST_CLR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_TRK: state_q <= ST_IDLE;
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (rdata != '0) begin
						state_q <= ST_EMIT;
					end else if (scan_end) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					res_valid_q <= 1'b1;
					if (bits_left == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idx_q      <= head.idx;
				mask_q     <= head_mask;
				set_q      <= head.set;
				res_msg_q  <= '0;
				res_has_q  <= 1'b0;
				res_last_q <= 1'b1;
				res_done_q <= 1'b1;
			end
			ST_SCAN: begin
				bits_q     <= rdata;
				ent_q      <= scan_q[IDX_W-1:0];
				res_msg_q  <= '0;
				res_has_q  <= 1'b0;
				res_last_q <= 1'b1;
				res_done_q <= 1'b1;
			end
			ST_EMIT: begin
				bits_q     <= bits_left;
				// port, zero velocity, note, note-on status with channel
				res_msg_q  <= {8'(low_sel), 8'd0, 1'b0, ent_q[6:0], NOTE_ON_HI, ent_q[10:7]};
				res_has_q  <= 1'b1;
				res_last_q <= (bits_left == '0);
				res_done_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign back_init    = init_q;
	assign result_valid = res_valid_q;
	assign out_message  = res_msg_q;
	assign has_note     = res_has_q;
	assign last_of_run  = res_last_q;
	assign scan_done    = res_done_q;

`ifndef SYNTH
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> bits_q != '0)
		else $error("emitting from an empty entry");
	a_done_no_note: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_done_q |-> !res_has_q && res_last_q)
		else $error("done result carries a note");
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= SCAN_W'(ENTRY_COUNT))
		else $error("scan index past end of store");
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE || state_q == ST_SCAN |-> !we)
		else $error("store written outside track or clear");
`endif

endmodule

[bench/hanging_note_tracker_tb.sv]
// Bench for hanging_note_tracker: a clocked driver offers queued words, a clocked monitor
// checks every strobed result against a local copy of the per-note port store.
// Depends on hnt_pkg and the hanging_note_tracker RTL.
module hanging_note_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hnt_pkg::*;

	localparam int PORTS        = 8;
	localparam int STALL_LIMIT  = 16384;
	localparam int TAIL_CYCLES  = 64;
	localparam int RANDOM_WORDS = 220;
	localparam int POOL_SIZE    = 12;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  act;
		logic [31:0] msg;
		bit          drain;
		int          gap_pct;
	} word_t;

	typedef struct packed {
		logic [31:0] out_message;
		logic        has_note;
		logic        last_of_run;
		logic        scan_done;
	} release_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        start   = 1'b0;
	logic [1:0]  action  = ACT_TRACK;
	logic [31:0] message = '0;
	logic        busy;
	logic        result_valid;
	logic [31:0] out_message;
	logic        has_note;
	logic        last_of_run;
	logic        scan_done;

	word_t    word_queue[$];
	release_t flush_answers[$];
	logic [7:0] sounding [ENTRY_COUNT];
	int       scan_ptr;
	int       mismatches;
	int       quiet_cycles;

	hanging_note_tracker #(.PORT_COUNT(PORTS)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.message     (message),
		.result_valid(result_valid),
		.out_message (out_message),
		.has_note    (has_note),
		.last_of_run (last_of_run),
		.scan_done   (scan_done)
	);

	always #4 clk = ~clk;

	// Update the note store for one accepted word and queue the results it causes.
	task automatic apply_word(input logic [1:0] act, input logic [31:0] msg);
		logic [31:0] ev;
		logic [10:0] idx;
		logic [7:0]  bits;
		int          port;
		release_t    r;
		ev = msg & EVENT_MASK;
		case (act)
		ACT_TRACK: begin
			port = int'(msg[30:24]);
			idx = {msg[3:0], msg[14:8]};
			if ((ev == EV_NOTE_ON || ev == EV_NOTE_OFF) && port < PORTS)
				sounding[idx][port] = (ev == EV_NOTE_ON && msg[23:16] != 8'd0);
		end
		ACT_FLUSH: begin
			while (scan_ptr < ENTRY_COUNT && sounding[scan_ptr] == 8'd0)
				scan_ptr++;
			if (scan_ptr >= ENTRY_COUNT) begin
				scan_ptr = ENTRY_COUNT;
				r = '{32'd0, 1'b0, 1'b1, 1'b1};
				flush_answers.insert(flush_answers.size(), r);
			end else begin
				bits = sounding[scan_ptr];
				idx = scan_ptr[10:0];
				for (port = 0; port < PORTS; port++) begin
					if (bits[port]) begin
						r.out_message = {5'd0, 3'(port), 8'd0, 1'b0, idx[6:0], NOTE_ON_HI,
							idx[10:7]};
						r.has_note = 1'b1;
						r.last_of_run = ((bits >> (port + 1)) == 8'd0);
						r.scan_done = 1'b0;
						flush_answers.insert(flush_answers.size(), r);
					end
				end
				scan_ptr++;
			end
		end
		ACT_CLEAR: begin
			foreach (sounding[i])
				sounding[i] = 8'd0;
			scan_ptr = 0;
		end
		default: ;
		endcase
	endtask

	task automatic queue_word(input logic [1:0] act, input logic [31:0] msg,
		input bit drain, input int gap_pct);
		word_t w;
		w.act = act;
		w.msg = msg;
		w.drain = drain;
		w.gap_pct = gap_pct;
		word_queue.insert(word_queue.size(), w);
	endtask

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", field, want, got);
			mismatches++;
		end
	endfunction

	// Driver: a word stays offered until busy is low at an edge.
	always @(posedge clk or negedge arst_n) begin : drive_words
		word_t w;
		bit    offer;
		if (!arst_n) begin
			start <= 1'b0;
			action <= ACT_TRACK;
			message <= '0;
			apply_word(ACT_CLEAR, '0);
		end else begin
			offer = start && busy;
			if (start && !busy)
				apply_word(action, message);
			if (!offer && word_queue.size() != 0) begin
				w = word_queue[0];
				if (!(w.drain && flush_answers.size() != 0) &&
					$urandom_range(99, 0) >= w.gap_pct) begin
					void'(word_queue.pop_front());
					offer = 1'b1;
					action <= w.act;
					message <= w.msg;
				end
			end
			start <= offer;
		end
	end

	always @(posedge clk) begin : check_results
		release_t want;
		if (arst_n && result_valid) begin
			if (flush_answers.size() == 0) begin
				$error("unexpected result word: out_message %h", out_message);
				mismatches++;
			end else begin
				want = flush_answers.pop_front();
				check_field("out_message", want.out_message, out_message);
				check_field("has_note", 32'(want.has_note), 32'(has_note));
				check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
				check_field("scan_done", 32'(want.scan_done), 32'(scan_done));
			end
		end
	end

	// Watchdog on cycles with no word accepted in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("hanging_note_tracker_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [10:0] pool [POOL_SIZE];
		logic [10:0] idx;
		logic [31:0] msg;
		int          n;
		int          kind;
		int          gap;
		int          p;
		bit          drain;
		foreach (pool[i])
			pool[i] = 11'($urandom);

		// empty store: first scan runs to the end, the second is exhausted at once
		queue_word(ACT_FLUSH, 32'hFFFF_FFFF, 0, 28);
		queue_word(ACT_FLUSH, 32'h0000_0000, 0, 28);
		queue_word(ACT_CLEAR, 32'h0000_0000, 1, 28);
		queue_word(ACT_TRACK, 32'h0001_0090, 0, 28);   // port 0, ch 0, note 0, vel 1
		queue_word(ACT_TRACK, 32'h07FF_FF9F, 0, 28);   // port 7, ch 15, note 127, bit 15 set
		queue_word(ACT_TRACK, 32'h0340_7F9F, 0, 28);   // port 3, same note
		queue_word(ACT_TRACK, 32'h0210_0090, 0, 28);   // port 2 on note 0
		queue_word(ACT_TRACK, 32'h0200_0090, 0, 28);   // zero velocity note-on releases it
		queue_word(ACT_TRACK, 32'h0340_7F8F, 0, 28);   // note-off releases port 3
		queue_word(ACT_TRACK, 32'h8640_0590, 0, 28);   // sysex index word, ignored
		queue_word(ACT_TRACK, 32'h0840_0590, 0, 28);   // port 8, ignored
		queue_word(ACT_TRACK, 32'h0140_05A0, 0, 28);   // aftertouch, ignored
		queue_word(ACT_UNUSED, 32'hFFFF_FFFF, 0, 28);
		queue_word(ACT_FLUSH, 32'h0000_0000, 0, 28);
		queue_word(ACT_TRACK, 32'h0120_0A93, 0, 28);   // lands mid-scan
		queue_word(ACT_FLUSH, 32'h0000_0000, 0, 28);
		queue_word(ACT_FLUSH, 32'h0000_0000, 0, 28);
		queue_word(ACT_FLUSH, 32'h0000_0000, 0, 28);
		queue_word(ACT_CLEAR, 32'h0000_0000, 0, 28);
		for (p = 0; p < PORTS; p++)
			queue_word(ACT_TRACK, {1'b0, 7'(p), 8'h55, 8'h40, 8'h99}, 0, 28);
		queue_word(ACT_FLUSH, 32'h0000_0000, 0, 28);
		queue_word(ACT_FLUSH, 32'h0000_0000, 0, 28);

		n = 0;
		while (n < RANDOM_WORDS) begin
			gap = (n < RANDOM_WORDS / 3) ? 28 : (n < 2 * RANDOM_WORDS / 3) ? 58 : 0;
			drain = (n == RANDOM_WORDS / 3 || n == 2 * RANDOM_WORDS / 3);
			kind = $urandom_range(99, 0);
			msg = $urandom;
			if (kind < 60) begin
				// mostly well-formed note traffic on a small set of notes, some noise
				if ($urandom_range(9, 0) < 8) begin
					idx = ($urandom_range(4, 0) != 0) ? pool[$urandom_range(POOL_SIZE - 1, 0)]
						: 11'($urandom);
					msg[31] = 1'b0;
					msg[30:24] = 7'($urandom_range(PORTS - 1, 0));
					msg[7:4] = ($urandom_range(2, 0) != 0) ? 4'h9 : 4'h8;
					msg[3:0] = idx[10:7];
					msg[14:8] = idx[6:0];
					if ($urandom_range(9, 0) == 0)
						msg[23:16] = 8'd0;
				end
				queue_word(ACT_TRACK, msg, drain, gap);
				n++;
			end else if (kind < 90) begin
				queue_word(ACT_FLUSH, msg, drain, gap);
				n++;
			end else if (kind < 94) begin
				queue_word(ACT_CLEAR, msg, drain, gap);
				n++;
			end else begin
				queue_word(ACT_UNUSED, msg, drain, gap);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (word_queue.size() != 0 || start)
			@(posedge clk);
		while (flush_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("hanging_note_tracker_tb: done, clean");
		else
			$display("hanging_note_tracker_tb: done, errors");
		$finish;
	end

endmodule
